### rtl/sensor_zero_auto_calibration_defines.svh
// assertion macros for the sensor zero auto-calibration block
// no dependencies; included by files that carry concurrent assertions
`ifndef SENSOR_ZERO_AUTO_CALIBRATION_DEFINES_SVH
`define SENSOR_ZERO_AUTO_CALIBRATION_DEFINES_SVH

`ifndef SYNTHESIS
`define SZAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define SZAC_NEVER(label, clk, rst_n, prop, msg) \
    `SZAC_ASSERT(label, clk, rst_n, !(prop), msg)
`else
`define SZAC_ASSERT(label, clk, rst_n, prop, msg)
`define SZAC_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

### rtl/szac_pkg.sv
// shared constants for the sensor zero auto-calibration block
// no dependencies
package szac_pkg;

    localparam int KIND_W     = 2;
    localparam int EVENT_W    = 2;
    localparam int MODE_W     = 2;
    localparam int ZP_W       = 16;
    localparam int CENTER_W   = 32;
    localparam int FRAC_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DW     = ((EVENT_W + MODE_W + ZP_W + CENTER_W + 7) / 8) * 8;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

    // phases, also reported as mode
    localparam logic [MODE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] PH_CAL  = 2'd1;
    localparam logic [MODE_W-1:0] PH_RUN  = 2'd2;
    localparam logic [MODE_W-1:0] PH_ERR  = 2'd3;

    // events
    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DONE    = 2'd1;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ZERO = 3'd5;

    // register reset values
    localparam int RST_REJECT_LIMIT = 10;
    localparam int RST_REQUIRED     = 100;
    localparam int RST_TIMEOUT      = 1000;

endpackage

### rtl/sensor_zero_auto_calibration.sv
// sensor zero auto-calibration: sample windowing, reject runs, averaging
// a start, stop or non-completing sample beat goes straight to the output register; the beat that completes
// calibration runs the restoring divider, one quotient bit per cycle, then waits in write-back for a free output
// register; one beat at a time
// synchronous active-low reset: idle phase, counters and sum cleared, registers at reset values
// depends on szac_pkg and sensor_zero_auto_calibration_defines.svh
`include "sensor_zero_auto_calibration_defines.svh"

module sensor_zero_auto_calibration
    import szac_pkg::*;
#(
    parameter int ADC_BITS   = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // tdata: angle_reading [ADC_BITS-1:0], encoder_count [ADC_BITS+31:ADC_BITS], zero pad
    input  logic [((ADC_BITS + CENTER_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    // tuser: kind [1:0]
    input  logic [KIND_W-1:0]                          i_s_tuser,
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // tdata: event_res [1:0], mode [3:2], zero_point [19:4], center_position [51:20], pad
    output logic [OUT_DW-1:0]                          o_m_tdata,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                      i_cfg_data
);

    localparam int SUM_W  = ADC_BITS + COUNT_BITS;
    localparam int Q_W    = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(Q_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // configuration registers
    logic [ADC_BITS-1:0]   r_window_low, r_window_high, r_default_zero;
    logic [COUNT_BITS-1:0] r_reject_limit, r_required, r_timeout;

    // block state
    logic [1:0]            r_state, n_state;
    logic [MODE_W-1:0]     r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_elapsed, n_elapsed;
    logic [COUNT_BITS-1:0] r_valid_cnt, n_valid_cnt;
    logic [COUNT_BITS-1:0] r_reject_run, n_reject_run;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [ZP_W-1:0]       r_learned, n_learned;
    logic                  r_have_learned, n_have_learned;
    logic [CENTER_W-1:0]   r_center, n_center;

    // divider
    logic [Q_W-1:0]        r_acc, n_acc;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_div, n_div;
    logic [STEP_W-1:0]     r_step, n_step;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [EVENT_W-1:0]    r_out_event, n_out_event;
    logic [MODE_W-1:0]     r_out_mode, n_out_mode;
    logic [ZP_W-1:0]       r_out_zp, n_out_zp;
    logic [CENTER_W-1:0]   r_out_center, n_out_center;

    logic                  in_beat, out_free;
    logic [KIND_W-1:0]     kind;
    logic [ADC_BITS-1:0]   reading;
    logic [CENTER_W-1:0]   encoder;
    logic                  in_win;
    logic [COUNT_BITS-1:0] el_inc, vc_upd, rr_upd;
    logic [SUM_W-1:0]      sum_upd;
    logic [31:0]           dz_wide;
    logic [ZP_W-1:0]       zp_cur, quo_sat;
    logic [COUNT_BITS:0]   rem_sh, rem_diff;
    logic                  rem_ge;

    assign kind    = i_s_tuser;
    assign reading = i_s_tdata[ADC_BITS-1:0];
    assign encoder = i_s_tdata[ADC_BITS+CENTER_W-1:ADC_BITS];

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign in_beat    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign dz_wide = 32'(r_default_zero) << FRAC_W;
    assign zp_cur  = r_have_learned ? r_learned : dz_wide[ZP_W-1:0];

    // sample update
    assign in_win  = (reading >= r_window_low) && (reading <= r_window_high);
    assign el_inc  = sat_inc(r_elapsed);
    assign rr_upd  = in_win ? '0 : sat_inc(r_reject_run);
    always_comb begin
        if (in_win) begin
            sum_upd = r_sum + SUM_W'(reading);
            vc_upd  = sat_inc(r_valid_cnt);
        end else if (rr_upd >= r_reject_limit) begin
            sum_upd = '0;
            vc_upd  = '0;
        end else begin
            sum_upd = r_sum;
            vc_upd  = r_valid_cnt;
        end
    end

    // restoring divider step
    assign rem_sh   = {r_rem, r_acc[Q_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign rem_diff = rem_sh - {1'b0, r_div};
    always_comb begin
        if (r_div == '0) begin
            quo_sat = '0;
        end else if (|r_acc[Q_W-1:ZP_W]) begin
            quo_sat = '1;
        end else begin
            quo_sat = r_acc[ZP_W-1:0];
        end
    end

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_elapsed      = r_elapsed;
        n_valid_cnt    = r_valid_cnt;
        n_reject_run   = r_reject_run;
        n_sum          = r_sum;
        n_learned      = r_learned;
        n_have_learned = r_have_learned;
        n_center       = r_center;
        n_acc          = r_acc;
        n_rem          = r_rem;
        n_div          = r_div;
        n_step         = r_step;
        n_out_valid    = r_out_valid && !i_m_tready;
        n_out_event    = r_out_event;
        n_out_mode     = r_out_mode;
        n_out_zp       = r_out_zp;
        n_out_center   = r_out_center;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_out_valid  = 1'b1;
                    n_out_event  = EV_NONE;
                    n_out_zp     = zp_cur;
                    n_out_center = r_center;
                    n_out_mode   = r_phase;
                    priority if (kind == KIND_START || kind == KIND_STOP) begin
                        n_elapsed    = '0;
                        n_valid_cnt  = '0;
                        n_reject_run = '0;
                        n_sum        = '0;
                        n_phase      = (kind == KIND_START) ? PH_CAL : PH_IDLE;
                        n_out_mode   = n_phase;
                    end else if (kind == KIND_SAMPLE && r_phase == PH_CAL) begin
                        n_elapsed    = el_inc;
                        n_valid_cnt  = vc_upd;
                        n_reject_run = rr_upd;
                        n_sum        = sum_upd;
                        if (vc_upd >= r_required) begin
                            n_phase     = PH_RUN;
                            n_center    = encoder;
                            n_acc       = {sum_upd, {FRAC_W{1'b0}}};
                            n_rem       = '0;
                            n_div       = vc_upd;
                            n_step      = STEP_W'(Q_W - 1);
                            n_state     = S_DIV;
                            n_out_valid = r_out_valid && !i_m_tready;
                        end else if (el_inc >= r_timeout) begin
                            n_phase     = PH_ERR;
                            n_out_mode  = PH_ERR;
                            n_out_event = EV_TIMEOUT;
                        end
                    end else begin
                    end
                end
            end
            S_DIV: begin
                n_acc = {r_acc[Q_W-2:0], rem_ge};
                n_rem = rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (out_free) begin
                    n_learned      = quo_sat;
                    n_have_learned = 1'b1;
                    n_out_valid    = 1'b1;
                    n_out_event    = EV_DONE;
                    n_out_mode     = r_phase;
                    n_out_zp       = quo_sat;
                    n_out_center   = r_center;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= PH_IDLE;
            r_elapsed      <= '0;
            r_valid_cnt    <= '0;
            r_reject_run   <= '0;
            r_sum          <= '0;
            r_learned      <= '0;
            r_have_learned <= 1'b0;
            r_center       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_phase        <= n_phase;
            r_elapsed      <= n_elapsed;
            r_valid_cnt    <= n_valid_cnt;
            r_reject_run   <= n_reject_run;
            r_sum          <= n_sum;
            r_learned      <= n_learned;
            r_have_learned <= n_have_learned;
            r_center       <= n_center;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_step       <= n_step;
        r_out_event  <= n_out_event;
        r_out_mode   <= n_out_mode;
        r_out_zp     <= n_out_zp;
        r_out_center <= n_out_center;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_low   <= '0;
            r_window_high  <= '1;
            r_default_zero <= {1'b1, {(ADC_BITS-1){1'b0}}};
            r_reject_limit <= COUNT_BITS'(RST_REJECT_LIMIT);
            r_required     <= COUNT_BITS'(RST_REQUIRED);
            r_timeout      <= COUNT_BITS'(RST_TIMEOUT);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW_LOW:   r_window_low   <= i_cfg_data[ADC_BITS-1:0];
                REG_WINDOW_HIGH:  r_window_high  <= i_cfg_data[ADC_BITS-1:0];
                REG_REJECT_LIMIT: r_reject_limit <= i_cfg_data[COUNT_BITS-1:0];
                REG_REQUIRED:     r_required     <= i_cfg_data[COUNT_BITS-1:0];
                REG_TIMEOUT:      r_timeout      <= i_cfg_data[COUNT_BITS-1:0];
                REG_DEFAULT_ZERO: r_default_zero <= i_cfg_data[ADC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'({r_out_center, r_out_zp, r_out_mode, r_out_event});

    `SZAC_ASSERT(a_div_in_run, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> (r_phase == PH_RUN), "divider busy outside running phase")
    `SZAC_ASSERT(a_done_mode, i_clk, i_rst_n,
        (o_m_tvalid && r_out_event == EV_DONE) |-> (r_out_mode == PH_RUN),
        "done event without running mode")
    `SZAC_ASSERT(a_timeout_mode, i_clk, i_rst_n,
        (o_m_tvalid && r_out_event == EV_TIMEOUT) |-> (r_out_mode == PH_ERR),
        "timeout event without error mode")
    `SZAC_NEVER(a_learned_kept, i_clk, i_rst_n, $fell(r_have_learned),
        "learned zero lost")
    `SZAC_ASSERT(a_div_end, i_clk, i_rst_n,
        (r_state == S_DIV && r_step == '0) |=> (r_state == S_WB),
        "divider did not hand over to write-back")

endmodule
